FILE: hdl/tpdp_pkg.sv
// Shared types and constants of the tablet packet deframer and parser.
// Used by every module of the block but the checker; depends on nothing.
package tpdp_pkg;

    localparam int PKT_SHORT = 7;
    localparam int PKT_LONG  = 9;
    localparam int IDX_W     = 4;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 14;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_AW-1:0] CFG_TILT_ENABLE = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_Y_MIN       = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_Y_MAX       = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_OFFSET_MAX  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_OFFSET_FUZZ = 3'd4;

    typedef struct packed {
        logic        tilt_enable;
        logic [13:0] y_min;
        logic [13:0] y_max;
        logic [6:0]  offset_max;
        logic [3:0]  offset_fuzz;
    } cfg_t;

    typedef struct packed {
        logic        prox;
        logic [13:0] x_raw;
        logic [13:0] y_raw;
        logic        btn_one;
        logic        btn_two;
        logic [6:0]  z_raw;
        logic [6:0]  tx_raw;
        logic [6:0]  ty_raw;
    } pkt_t;

    typedef struct packed {
        logic [13:0] x_pos;
        logic [13:0] y_pos;
        logic [6:0]  pressure;
        logic        contact;
        logic        in_range;
        logic        button_one;
        logic        button_two;
        logic [6:0]  tilt_x;
        logic [6:0]  tilt_y;
    } result_t;

endpackage

FILE: hdl/tpdp_front.sv
// Front end: collects serial bytes into a packet and emits finished packets.
// Depends on tpdp_pkg.
module tpdp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  tpdp_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_serial_byte,
    output logic                push,
    output tpdp_pkg::pkt_t      push_pkt,
    input  logic                queue_full
);
    import tpdp_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       pkt_reg [PKT_LONG];
    logic [7:0]       pkt_next [PKT_LONG];
    logic [IDX_W-1:0] wr_idx, idx_inc, len;
    logic             store, accept, emit;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        wr_idx  = s_serial_byte[7] ? '0 : idx_reg;
        len     = cfg.tilt_enable ? IDX_W'(PKT_LONG) : IDX_W'(PKT_SHORT);
        store   = wr_idx < IDX_W'(PKT_LONG);
        idx_inc = store ? wr_idx + IDX_W'(1) : IDX_W'(PKT_LONG + 1);
        for (int k = 0; k < PKT_LONG; k++) begin
            pkt_next[k] = (store && wr_idx == IDX_W'(k)) ? s_serial_byte : pkt_reg[k];
        end
        emit     = idx_inc == len;
        idx_next = idx_reg;
        if (accept) begin
            idx_next = (idx_inc >= len) ? '0 : idx_inc;
        end
    end

    always_comb begin
        push_pkt.prox    = pkt_next[0][6];
        push_pkt.x_raw   = {pkt_next[1][6:0], pkt_next[2][6:0]};
        push_pkt.y_raw   = {pkt_next[4][6:0], pkt_next[5][6:0]};
        push_pkt.btn_one = pkt_next[3][4];
        push_pkt.btn_two = pkt_next[3][5];
        push_pkt.z_raw   = pkt_next[6][6:0];
        push_pkt.tx_raw  = pkt_next[7][6:0];
        push_pkt.ty_raw  = pkt_next[8][6:0];
    end

    assign push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pkt_reg <= pkt_next;
        end
    end

endmodule

FILE: hdl/tpdp_queue.sv
// Short packet queue between the front end and the decoder.
// Depends on tpdp_pkg.
module tpdp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tpdp_pkg::pkt_t push_pkt,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output tpdp_pkg::pkt_t pop_pkt
);
    import tpdp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    pkt_t            mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = count_reg == CW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_pkt   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

FILE: hdl/tpdp_back.sv
// Decoder: turns queued packets into results, tracks the pressure floor.
// Depends on tpdp_pkg.
module tpdp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  tpdp_pkg::cfg_t    cfg,
    input  logic              not_empty,
    input  tpdp_pkg::pkt_t    pkt,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output tpdp_pkg::result_t result
);
    import tpdp_pkg::*;

    logic        valid_reg, valid_next;
    result_t     res_reg, res_next;
    logic [6:0]  min_reg, min_next;
    logic [7:0]  po_reg, po_next;
    logic [6:0]  z;
    logic [14:0] y_sum;
    logic [13:0] y_hi;
    logic [7:0]  z_diff;

    assign pop     = not_empty && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign result  = res_reg;

    always_comb begin
        z = {pkt.prox && !pkt.z_raw[6], pkt.z_raw[5:0]};
        min_next = min_reg;
        po_next  = po_reg;
        if (!pkt.prox) begin
            min_next = cfg.offset_max;
        end else begin
            min_next = (z < min_reg) ? z : min_reg;
            po_next  = {1'b0, min_next} + {4'b0, cfg.offset_fuzz};
        end
        if (!pop) begin
            min_next = min_reg;
            po_next  = po_reg;
        end

        y_sum  = {1'b0, pkt.y_raw} + {2'b0, cfg.y_min[13:1]};
        y_hi   = (y_sum > {1'b0, cfg.y_max}) ? cfg.y_max : y_sum[13:0];
        z_diff = {1'b0, z} - po_next;

        res_next.x_pos      = pkt.x_raw;
        res_next.y_pos      = (y_hi < cfg.y_min) ? cfg.y_min : y_hi;
        res_next.pressure   = ({1'b0, z} > po_next) ? z_diff[6:0] : '0;
        res_next.contact    = {1'b0, z} > po_next;
        res_next.in_range   = pkt.prox;
        res_next.button_one = pkt.btn_one;
        res_next.button_two = pkt.btn_two;
        res_next.tilt_x     = cfg.tilt_enable ? {~pkt.tx_raw[6], pkt.tx_raw[5:0]} : '0;
        res_next.tilt_y     = cfg.tilt_enable ? {~pkt.ty_raw[6], pkt.ty_raw[5:0]} : '0;

        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            min_reg   <= '0;
            po_reg    <= '0;
        end else begin
            valid_reg <= valid_next;
            min_reg   <= min_next;
            po_reg    <= po_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: hdl/tablet_packet_deframe_parse.sv
// Top level of the pen tablet packet deframer and parser.
// Depends on tpdp_pkg, tpdp_front, tpdp_queue and tpdp_back.
//
// The s_ channel takes one serial byte per request. A byte with bit 7 set
// restarts the packet. When 7 bytes are held, or 9 with tilt enabled, the
// packet goes into a two-entry queue and the decoder turns it into one
// result request on the m_ channel: position, buttons, proximity, pressure
// with drift correction and contact, and tilt.
// One byte is accepted every cycle while the queue is not full. The result
// of a packet passes first through the packet queue and then through the
// registered output of the decoder before it appears on m_valid.
// When the receiver stalls, the output register holds its result, the queue
// absorbs up to two more packets, and s_ready falls only when the queue is
// full. Reset clears the byte count, the queue, the output valid, the
// pressure tracking and restores the register defaults.
// Registers are written through cfg_we, cfg_addr and cfg_wdata while the
// block is idle, by the user (not enforced); unknown indexes are ignored.
module tablet_packet_deframe_parse (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tpdp_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [tpdp_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_serial_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [13:0]                   m_x_pos,
    output logic [13:0]                   m_y_pos,
    output logic [6:0]                    m_pressure,
    output logic                          m_contact,
    output logic                          m_in_range,
    output logic                          m_button_one,
    output logic                          m_button_two,
    output logic [6:0]                    m_tilt_x,
    output logic [6:0]                    m_tilt_y
);
    import tpdp_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    push, queue_full, pop, not_empty;
    pkt_t    push_pkt, pop_pkt;
    result_t result;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TILT_ENABLE: cfg_next.tilt_enable = cfg_wdata[0];
                CFG_Y_MIN:       cfg_next.y_min       = cfg_wdata[13:0];
                CFG_Y_MAX:       cfg_next.y_max       = cfg_wdata[13:0];
                CFG_OFFSET_MAX:  cfg_next.offset_max  = cfg_wdata[6:0];
                CFG_OFFSET_FUZZ: cfg_next.offset_fuzz = cfg_wdata[3:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tilt_enable <= 1'b1;
            cfg_reg.y_min       <= 14'd1920;
            cfg_reg.y_max       <= 14'd7680;
            cfg_reg.offset_max  <= 7'd15;
            cfg_reg.offset_fuzz <= 4'd2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tpdp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_serial_byte (s_serial_byte),
        .push          (push),
        .push_pkt      (push_pkt),
        .queue_full    (queue_full)
    );

    tpdp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_pkt  (push_pkt),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_pkt   (pop_pkt)
    );

    tpdp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .not_empty (not_empty),
        .pkt       (pop_pkt),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result)
    );

    assign m_x_pos      = result.x_pos;
    assign m_y_pos      = result.y_pos;
    assign m_pressure   = result.pressure;
    assign m_contact    = result.contact;
    assign m_in_range   = result.in_range;
    assign m_button_one = result.button_one;
    assign m_button_two = result.button_two;
    assign m_tilt_x     = result.tilt_x;
    assign m_tilt_y     = result.tilt_y;

endmodule

FILE: hdl/tpdp_checker.sv
// Port-level checks of the tablet packet parser, bound to its top level.
// Depends only on the top level's ports.
module tpdp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [13:0] m_x_pos,
    input logic [13:0] m_y_pos,
    input logic [6:0]  m_pressure,
    input logic        m_contact
);

    a_reset_clears_valid: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_contact_matches_pressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_contact == (m_pressure != 7'd0)))
        else $error("contact disagrees with pressure");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result request dropped while stalled");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_x_pos) && $stable(m_y_pos) && $stable(m_pressure))
        else $error("result changed while stalled");

endmodule

bind tablet_packet_deframe_parse tpdp_checker u_tpdp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_x_pos    (m_x_pos),
    .m_y_pos    (m_y_pos),
    .m_pressure (m_pressure),
    .m_contact  (m_contact)
);

FILE: test/tb_tablet_packet_deframe_parse.sv
`timescale 1ns / 1ps
// Testbench of tablet_packet_deframe_parse: directed and random serial bytes go in, and each
// decoded tablet report is checked in order against a packet predictor. Depends on tpdp_pkg.
module tb_tablet_packet_deframe_parse;
    import tpdp_pkg::*;

    typedef logic [7:0] byte_seq_t[$];

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RESULT_LATENCY = 4;
    localparam int PHASE_BYTES    = 250;
    localparam int NUM_PHASES     = 8;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_we        = 1'b0;
    logic [CFG_AW-1:0] cfg_addr      = '0;
    logic [CFG_DW-1:0] cfg_wdata     = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [7:0]        s_serial_byte = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [13:0]       m_x_pos;
    logic [13:0]       m_y_pos;
    logic [6:0]        m_pressure;
    logic              m_contact;
    logic              m_in_range;
    logic              m_button_one;
    logic              m_button_two;
    logic [6:0]        m_tilt_x;
    logic [6:0]        m_tilt_y;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;

    cfg_t       cfg_shadow = '{tilt_enable: 1'b1, y_min: 14'd1920, y_max: 14'd7680,
                               offset_max: 7'd15, offset_fuzz: 4'd2};
    logic [7:0] pkt_buf[PKT_LONG];
    int         pkt_count    = 0;
    logic [6:0] min_press    = '0;
    logic [7:0] press_offset = '0;
    result_t    expected_reports[$];

    tablet_packet_deframe_parse dut (.*);

    always #4 aclk = ~aclk;

    function automatic logic [6:0] recentre_tilt(logic [7:0] v);
        logic [6:0] t;
        t = v[6:0];
        return (t > 7'd63) ? t - 7'd64 : t + 7'd64;
    endfunction

    function automatic result_t decode_report();
        result_t r;
        logic    prox;
        int      y;
        int      z;
        prox    = pkt_buf[0][6];
        r.x_pos = {pkt_buf[1][6:0], pkt_buf[2][6:0]};
        y = int'({pkt_buf[4][6:0], pkt_buf[5][6:0]}) + int'(cfg_shadow.y_min >> 1);
        if (y > int'(cfg_shadow.y_max)) y = int'(cfg_shadow.y_max);
        if (y < int'(cfg_shadow.y_min)) y = int'(cfg_shadow.y_min);
        r.y_pos = y[13:0];
        z = int'(pkt_buf[6][5:0]) + ((prox && !pkt_buf[6][6]) ? 64 : 0);
        if (cfg_shadow.tilt_enable) begin
            r.tilt_x = recentre_tilt(pkt_buf[7]);
            r.tilt_y = recentre_tilt(pkt_buf[8]);
        end else begin
            r.tilt_x = '0;
            r.tilt_y = '0;
        end
        if (!prox) begin
            min_press = cfg_shadow.offset_max;
        end else begin
            if (z < int'(min_press)) min_press = z[6:0];
            press_offset = {1'b0, min_press} + {4'b0, cfg_shadow.offset_fuzz};
        end
        z = (z > int'(press_offset)) ? z - int'(press_offset) : 0;
        r.pressure   = z[6:0];
        r.contact    = (z > 0);
        r.in_range   = prox;
        r.button_one = pkt_buf[3][4];
        r.button_two = pkt_buf[3][5];
        return r;
    endfunction

    task automatic absorb_byte(logic [7:0] b);
        int len;
        len = cfg_shadow.tilt_enable ? PKT_LONG : PKT_SHORT;
        if (b[7]) pkt_count = 0;
        if (pkt_count < PKT_LONG) begin
            pkt_buf[pkt_count] = b;
            pkt_count++;
        end else begin
            pkt_count = PKT_LONG + 1;
        end
        if (pkt_count > len) begin
            pkt_count = 0;
        end else if (pkt_count == len) begin
            expected_reports.push_back(decode_report());
            pkt_count = 0;
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_report();
        result_t want;
        if (expected_reports.size() == 0) begin
            mismatches++;
            $display("%0t: report with no completed packet pending", $time);
        end else begin
            want = expected_reports.pop_front();
            check_field("x_pos", want.x_pos, m_x_pos);
            check_field("y_pos", want.y_pos, m_y_pos);
            check_field("pressure", want.pressure, m_pressure);
            check_field("contact", want.contact, m_contact);
            check_field("in_range", want.in_range, m_in_range);
            check_field("button_one", want.button_one, m_button_one);
            check_field("button_two", want.button_two, m_button_two);
            check_field("tilt_x", want.tilt_x, m_tilt_x);
            check_field("tilt_y", want.tilt_y, m_tilt_y);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) absorb_byte(s_serial_byte);
            if (m_valid && m_ready) check_report();
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_serial_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_bytes(byte_seq_t seq);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic hold_sender();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_reports.size() != 0);
    endtask

    task automatic settle();
        hold_sender();
        repeat (RESULT_LATENCY) @(posedge aclk);
    endtask

    task automatic apply_config(cfg_t c);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TILT_ENABLE;
        cfg_wdata <= CFG_DW'(c.tilt_enable);
        @(posedge aclk);
        cfg_shadow.tilt_enable = c.tilt_enable;
        cfg_addr  <= CFG_Y_MIN;
        cfg_wdata <= CFG_DW'(c.y_min);
        @(posedge aclk);
        cfg_shadow.y_min = c.y_min;
        cfg_addr  <= CFG_Y_MAX;
        cfg_wdata <= CFG_DW'(c.y_max);
        @(posedge aclk);
        cfg_shadow.y_max = c.y_max;
        cfg_addr  <= CFG_OFFSET_MAX;
        cfg_wdata <= CFG_DW'(c.offset_max);
        @(posedge aclk);
        cfg_shadow.offset_max = c.offset_max;
        cfg_addr  <= CFG_OFFSET_FUZZ;
        cfg_wdata <= CFG_DW'(c.offset_fuzz);
        @(posedge aclk);
        cfg_shadow.offset_fuzz = c.offset_fuzz;
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned field_value(int unsigned max_value);
        if ($urandom_range(3) == 0) return $urandom_range(1) ? max_value : 0;
        return $urandom_range(max_value);
    endfunction

    function automatic cfg_t random_config();
        cfg_t        c;
        logic [13:0] t;
        c.tilt_enable = 1'($urandom);
        c.y_min       = 14'(field_value(16383));
        c.y_max       = 14'(field_value(16383));
        c.offset_max  = 7'(field_value(127));
        c.offset_fuzz = 4'(field_value(15));
        if ($urandom_range(3) != 0 && c.y_min > c.y_max) begin
            t       = c.y_min;
            c.y_min = c.y_max;
            c.y_max = t;
        end
        return c;
    endfunction

    // Mostly whole packets with random content, plus cut-short packets and stray bytes.
    task automatic random_traffic(int n_bytes);
        int         sent = 0;
        int         len;
        int         kind;
        int         nbody;
        logic [7:0] b;
        while (sent < n_bytes) begin
            len  = cfg_shadow.tilt_enable ? PKT_LONG : PKT_SHORT;
            kind = $urandom_range(99);
            if (kind < 10) begin
                send_byte(8'($urandom));
                sent++;
            end else begin
                nbody = (kind < 20) ? $urandom_range(len - 2) : len - 1;
                b = {1'b1, 1'($urandom_range(99) < 70), 6'($urandom)};
                send_byte(b);
                sent++;
                for (int i = 1; i <= nbody; i++) begin
                    send_byte({1'b0, 7'($urandom)});
                    sent++;
                end
            end
        end
    endtask

    task automatic test_reset_defaults();
        // Full-scale packet under the reset settings: Y clamps to the top of the window.
        send_bytes('{8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F});
    endtask

    task automatic test_overlong_packet();
        cfg_t c;
        send_bytes('{8'hC0, 8'h11, 8'h22, 8'h10, 8'h33, 8'h44, 8'h05, 8'h40});
        settle();
        // Shorter packets with an inverted Y window and all offsets at their maximum.
        c = '{tilt_enable: 1'b0, y_min: 14'h3FFF, y_max: 14'h0000,
              offset_max: 7'h7F, offset_fuzz: 4'hF};
        apply_config(c);
        // Eight bytes are already held, so this one overruns the packet and is dropped.
        send_byte(8'h01);
        // A packet without a start byte, pen out of range.
        send_bytes('{8'h00, 8'h01, 8'h02, 8'h20, 8'h7F, 8'h7F, 8'h3F});
        // Pen in range with a low pressure byte, which gets the upper half added.
        send_bytes('{8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    task automatic test_random_phase(int phase);
        cfg_t c;
        settle();
        case (phase % 4)
            0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            1: begin src_idle_pct = 78; snk_idle_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_idle_pct = 78; end
            default: begin src_idle_pct = 9; snk_idle_pct = 9; end
        endcase
        if (phase == 1) begin
            c = '{tilt_enable: 1'b1, y_min: 14'h3FFF, y_max: 14'h3FFF,
                  offset_max: 7'h7F, offset_fuzz: 4'hF};
        end else if (phase == 3) begin
            c = '0;
        end else begin
            c = random_config();
        end
        apply_config(c);
        random_traffic(PHASE_BYTES / 2);
        if (phase == 2) hold_sender();
        random_traffic(PHASE_BYTES / 2);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_overlong_packet();
        for (int p = 0; p < NUM_PHASES; p++) test_random_phase(p);
        hold_sender();
        repeat (2 * RESULT_LATENCY) @(posedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (expected_reports.size() != 0)
                $display("%0t: %0d reports never arrived", $time, expected_reports.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
